>>> design/aso_pkg.sv
package aso_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 2;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE = 1'd1;

	localparam logic [3:0] SETTLE_RST    = 4'd1;
	localparam logic [6:0] OVERSAMPLE_RST = 7'd16;
	localparam logic [6:0] OVERSAMPLE_MAX = 7'd64;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [9:0] sample_value;
		logic [2:0] read_channel;
	} aso_in_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic [2:0]  active_channel;
		logic        result_stored;
	} aso_out_t;

endpackage

>>> design/adc_scan_oversampler_unit.sv
// ADC channel scanner with settling discard and oversampling accumulation.
// Input channel (in_valid/in_ready/in_data): one beat is either a converter
// sample for the active channel or a read request for one channel's stored sum.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per
// input beat, in order, carrying the read value, the channel to sample next and
// a flag set when a sample completed a channel sum.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 = settle
// samples, 1 = oversample count) at the clock edge; write only while idle.
// A beat held in the input stage moves into the output register once it can
// advance. Throughput: one beat per cycle while out_ready is high; the
// accumulator add, the count compare and the channel advance are
// combinational between the input stage and the output register.
// Reset (arst_n low): accumulator, sample count, active channel and all stored
// channel sums clear; registers return to settle 1, oversample 16.
// Stall: with out_ready low the output register holds its beat and the input
// stage still takes one more beat; in_ready drops once both are full.
module adc_scan_oversampler_unit #(
	parameter int unsigned NUM_CHANNELS = aso_pkg::NUM_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [aso_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aso_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  aso_pkg::aso_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output aso_pkg::aso_out_t               out_data
);
	import aso_pkg::*;

	aso_in_t  item_s1;
	logic     vld_s1;
	aso_out_t res;
	aso_out_t res_s2;
	logic     vld_s2;
	logic     advance;

	assign advance  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	aso_core #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (advance),
		.item     (item_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

endmodule

>>> design/aso_core.sv
module aso_core #(
	parameter int unsigned NUM_CHANNELS = aso_pkg::NUM_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [aso_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aso_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            step,
	input  aso_pkg::aso_in_t                item,
	output aso_pkg::aso_out_t               res
);
	import aso_pkg::*;

	localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [3:0]  settle_q;
	logic [6:0]  oversample_q;
	logic [15:0] sum_q;
	logic [6:0]  cnt_q;
	logic [2:0]  chan_q;
	logic [15:0] sums_q [NUM_CHANNELS];

	logic [6:0]  eff_count;
	logic [6:0]  last_cnt;
	logic        is_sample;
	logic        in_settle;
	logic        done;
	logic [15:0] sum_acc;
	logic [2:0]  chan_nxt;
	logic        rd_hit;

	always_comb begin
		if (oversample_q == 7'd0) begin
			eff_count = 7'd1;
		end else if (oversample_q > OVERSAMPLE_MAX) begin
			eff_count = OVERSAMPLE_MAX;
		end else begin
			eff_count = oversample_q;
		end
	end

	assign last_cnt  = {3'd0, settle_q} + eff_count - 7'd1;
	assign is_sample = (item.req_type == REQ_SAMPLE);
	assign in_settle = (cnt_q >= {3'd0, settle_q});
	assign done      = (cnt_q >= last_cnt);
	assign sum_acc   = in_settle ? (sum_q + {6'd0, item.sample_value}) : sum_q;
	assign chan_nxt  = (({1'b0, chan_q} + 4'd1) >= 4'(NUM_CHANNELS)) ? 3'd0 : (chan_q + 3'd1);
	assign rd_hit    = ({1'b0, item.read_channel} < 4'(NUM_CHANNELS));

	always_comb begin
		res.read_value     = (!is_sample && rd_hit) ? sums_q[item.read_channel[IdxW-1:0]] : 16'd0;
		res.active_channel = (is_sample && done) ? chan_nxt : chan_q;
		res.result_stored  = is_sample && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q     <= SETTLE_RST;
			oversample_q <= OVERSAMPLE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SETTLE:     settle_q     <= cfg_data[3:0];
				CFG_OVERSAMPLE: oversample_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= 16'd0;
			cnt_q  <= 7'd0;
			chan_q <= 3'd0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sums_q[i] <= 16'd0;
			end
		end else if (step && is_sample) begin
			if (done) begin
				sums_q[chan_q[IdxW-1:0]] <= sum_acc;
				sum_q  <= 16'd0;
				cnt_q  <= 7'd0;
				chan_q <= chan_nxt;
			end else begin
				sum_q <= sum_acc;
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

endmodule

>>> design/aso_checker.sv
module aso_checker #(
	parameter int unsigned NUM_CHANNELS = aso_pkg::NUM_CHANNELS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input aso_pkg::aso_out_t out_data
);
	import aso_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.read_value == 16'd0) || !out_data.result_stored)
		else $error("read value and stored flag on the same beat");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.active_channel} < 4'(NUM_CHANNELS)))
		else $error("active channel out of range");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind adc_scan_oversampler_unit aso_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_aso_checker (.*);
